>>> hdl/decimal_text_to_fixed_point_macros.svh
// Assertion macros shared by the parser modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DTFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtfp assertion failed");
`define DTFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtfp assertion failed");
`else
`define DTFP_ASSERT_IMPL(label, ante, cons)
`define DTFP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hdl/dtfp_pkg.sv
package dtfp_pkg;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_INT,
    PH_FRAC
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNTAX   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] fixed_value;
    status_t            parse_status;
  } out_word_t;

  typedef struct packed {
    logic    load;
    logic    negative;
    status_t status;
  } final_req_t;

  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_PERIOD = 8'd46;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;

  localparam logic [63:0] POW_TEN [0:9] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000
  };

  localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

>>> hdl/dtfp_stream_if.sv
interface dtfp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hdl/dtfp_out_reg.sv
`include "decimal_text_to_fixed_point_macros.svh"

module dtfp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  dtfp_pkg::final_req_t req,
  input  logic [63:0]         mag,
  dtfp_stream_if.source       result_out
);
  import dtfp_pkg::*;

  logic [63:0] sat_mag;
  logic [63:0] value_next;

  assign sat_mag = mag[63] ? MAG_MAX : mag;

  always_comb begin
    if (req.status != ST_OK) begin
      value_next = 64'd0;
    end else if (req.negative) begin
      value_next = 64'd0 - sat_mag;
    end else begin
      value_next = sat_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (req.load) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      result_out.data.fixed_value  <= value_next;
      result_out.data.parse_status <= req.status;
    end
  end

  `DTFP_ASSERT_IMPL(a_err_zero, result_out.valid && result_out.data.parse_status != ST_OK, result_out.data.fixed_value == 64'sd0)
  `DTFP_ASSERT_IMPL(a_no_min, result_out.valid, result_out.data.fixed_value != 64'sh8000_0000_0000_0000)
  `DTFP_ASSERT_IMPL(a_no_load_stalled, result_out.valid && !result_out.ready, !req.load)
  `DTFP_ASSERT_NEXT(a_load_shows, req.load, result_out.valid)

endmodule

>>> hdl/decimal_text_to_fixed_point.sv
// A terminator word's result is loaded into the result register when the word is accepted.
// Throughput: one text word per cycle, limited by the single result register.
// Input words stall only while a result waits in that register and the sink is not ready.
// Reset (rst, synchronous, active high) returns the parser to leading whitespace.
// Reset also empties the result register.
`include "decimal_text_to_fixed_point_macros.svh"

module decimal_text_to_fixed_point #(
  parameter int FRAC_BITS       = 32,
  parameter int INT_BITS        = 31,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic          clk,
  input  logic          rst,
  dtfp_stream_if.sink   text_in,
  dtfp_stream_if.source result_out
);
  import dtfp_pkg::*;

  localparam int IW = INT_BITS + 4;
  localparam int PW = FRAC_BITS + 4;

  localparam logic [FRAC_BITS-1:0] FRAC_WEIGHT [0:8] = '{
    FRAC_BITS'(((64'd1 << FRAC_BITS) + POW_TEN[1] / 2) / POW_TEN[1]),
    FRAC_BITS'(((64'd1 << FRAC_BITS) + POW_TEN[2] / 2) / POW_TEN[2]),
    FRAC_BITS'(((64'd1 << FRAC_BITS) + POW_TEN[3] / 2) / POW_TEN[3]),
    FRAC_BITS'(((64'd1 << FRAC_BITS) + POW_TEN[4] / 2) / POW_TEN[4]),
    FRAC_BITS'(((64'd1 << FRAC_BITS) + POW_TEN[5] / 2) / POW_TEN[5]),
    FRAC_BITS'(((64'd1 << FRAC_BITS) + POW_TEN[6] / 2) / POW_TEN[6]),
    FRAC_BITS'(((64'd1 << FRAC_BITS) + POW_TEN[7] / 2) / POW_TEN[7]),
    FRAC_BITS'(((64'd1 << FRAC_BITS) + POW_TEN[8] / 2) / POW_TEN[8]),
    FRAC_BITS'(((64'd1 << FRAC_BITS) + POW_TEN[9] / 2) / POW_TEN[9])
  };

  phase_t              phase, phase_next;
  logic                is_negative, is_negative_next;
  logic [INT_BITS-1:0] integer_part, integer_part_next;
  logic [63:0]         frac_acc, frac_acc_next;
  logic [3:0]          frac_count, frac_count_next;
  status_t             error_code, error_code_next;

  logic        in_fire;
  logic [7:0]  c;
  logic        is_digit;
  logic        is_space;
  logic [3:0]  d;
  logic [IW-1:0] int_ext;
  logic [IW-1:0] int_wide;
  logic        int_ovf;
  logic [PW-1:0] digit_weight;
  logic [63:0] int_shifted;
  logic        take_int;
  final_req_t  req;
  logic [63:0] mag;

  assign text_in.ready = !result_out.valid || result_out.ready;
  assign in_fire       = text_in.valid && text_in.ready;
  assign c             = text_in.data.text_byte;

  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_space = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  assign d        = 4'(c - CH_ZERO);

  assign int_ext  = IW'(integer_part);
  assign int_wide = (int_ext << 3) + (int_ext << 1) + IW'(d);
  assign int_ovf  = |int_wide[IW-1:INT_BITS];

  assign digit_weight = PW'(d) * PW'(FRAC_WEIGHT[frac_count]);
  assign int_shifted  = 64'(integer_part) << FRAC_BITS;

  assign take_int = (phase == PH_SIGNED) || (phase == PH_INT) ||
                    ((phase == PH_SPACE) && !is_space && (c != CH_PLUS) && (c != CH_MINUS));

  assign mag = (phase == PH_FRAC) ? frac_acc : int_shifted;

  always_comb begin
    phase_next        = phase;
    is_negative_next  = is_negative;
    integer_part_next = integer_part;
    frac_acc_next     = frac_acc;
    frac_count_next   = frac_count;
    error_code_next   = error_code;
    req.load          = 1'b0;
    req.negative      = is_negative;
    req.status        = error_code;
    if ((error_code == ST_OK) && ((phase == PH_SPACE) || (phase == PH_SIGNED))) begin
      req.status = ST_SYNTAX;
    end

    if (in_fire) begin
      if (c == CH_NUL) begin
        req.load          = 1'b1;
        phase_next        = PH_SPACE;
        is_negative_next  = 1'b0;
        integer_part_next = '0;
        frac_acc_next     = 64'd0;
        frac_count_next   = 4'd0;
        error_code_next   = ST_OK;
      end else if (error_code == ST_OK) begin
        if (take_int) begin
          if (is_digit) begin
            if (int_ovf) begin
              error_code_next = ST_OVERFLOW;
            end else begin
              integer_part_next = int_wide[INT_BITS-1:0];
              phase_next        = PH_INT;
            end
          end else if ((c == CH_PERIOD) && (phase == PH_INT)) begin
            phase_next    = PH_FRAC;
            frac_acc_next = int_shifted;
          end else begin
            error_code_next = ST_SYNTAX;
          end
        end else if (phase == PH_SPACE) begin
          if (!is_space) begin
            is_negative_next = (c == CH_MINUS);
            phase_next       = PH_SIGNED;
          end
        end else begin
          if (!is_digit) begin
            error_code_next = ST_SYNTAX;
          end else if (frac_count < 4'(MAX_FRAC_DIGITS)) begin
            frac_count_next = frac_count + 4'd1;
            frac_acc_next   = frac_acc + 64'(digit_weight);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SPACE;
      is_negative  <= 1'b0;
      integer_part <= '0;
      frac_acc     <= 64'd0;
      frac_count   <= 4'd0;
      error_code   <= ST_OK;
    end else begin
      phase        <= phase_next;
      is_negative  <= is_negative_next;
      integer_part <= integer_part_next;
      frac_acc     <= frac_acc_next;
      frac_count   <= frac_count_next;
      error_code   <= error_code_next;
    end
  end

  dtfp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .mag        (mag),
    .result_out (result_out)
  );

  `DTFP_ASSERT_NEXT(a_term_resets, in_fire && c == CH_NUL, phase == PH_SPACE && error_code == ST_OK && frac_count == 4'd0)
  `DTFP_ASSERT_IMPL(a_count_bound, 1'b1, frac_count <= 4'(MAX_FRAC_DIGITS))
  `DTFP_ASSERT_IMPL(a_count_in_frac, frac_count != 4'd0, phase == PH_FRAC)
  `DTFP_ASSERT_NEXT(a_err_sticky, in_fire && error_code != ST_OK && c != CH_NUL, error_code == $past(error_code) && integer_part == $past(integer_part) && frac_acc == $past(frac_acc))

endmodule
